// ===== design/fpls_pkg.sv =====
// Package for the weighted Fitch parsimony block: widths, lane count and stage types.
// Used by the channel interfaces and every module of the design.
package fpls_pkg;

  localparam int LANES       = 8;
  localparam int SCORE_BITS  = 24;
  localparam int LANE_W      = 8;
  localparam int SET_W       = 64;
  localparam int LIMIT_W     = 24;
  localparam int OUT_SCORE_W = 24;
  localparam int SUM_W       = LANE_W + $clog2(LANES + 1);
  localparam int CMP_W       = (SCORE_BITS > LIMIT_W) ? SCORE_BITS : LIMIT_W;
  localparam logic [LANE_W-1:0] LANE_MASK = 8'hFF;

  localparam logic MODE_SCORE_ONLY = 1'b1;

  typedef logic [LANE_W-1:0] lane_t;

  // Contents of the register stage after the lanes and the weight sum.
  typedef struct packed {
    logic               mode;
    logic [SET_W-1:0]   merged;
    logic [SUM_W-1:0]   added;
    logic [LIMIT_W-1:0] limit;
    logic               last;
  } stage1_t;

endpackage

// ===== design/fpls_if.sv =====
// Valid/ready channel interfaces for the input blocks and the result beats.
// Depends on fpls_pkg for field widths.
interface fpls_in_if;
  import fpls_pkg::*;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [SET_W-1:0]   set_a;
  logic [SET_W-1:0]   set_b;
  logic [SET_W-1:0]   site_weights;
  logic [LIMIT_W-1:0] score_limit;
  logic               last_block;

  modport source (output valid, mode, set_a, set_b, site_weights, score_limit, last_block,
                  input ready);
  modport sink (input valid, mode, set_a, set_b, site_weights, score_limit, last_block,
                output ready);
endinterface

interface fpls_out_if;
  import fpls_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [SET_W-1:0]       merged_set;
  logic [OUT_SCORE_W-1:0] running_score;
  logic                   limit_exceeded;
  logic                   last_result;

  modport source (output valid, merged_set, running_score, limit_exceeded, last_result,
                  input ready);
  modport sink (input valid, merged_set, running_score, limit_exceeded, last_result,
                output ready);
endinterface

// ===== design/fpls_lane.sv =====
// One site lane: Fitch intersection or union of two state sets and the weight it costs.
// Depends on fpls_pkg.
module fpls_lane (
  input  fpls_pkg::lane_t set_a,
  input  fpls_pkg::lane_t set_b,
  input  fpls_pkg::lane_t weight,
  output fpls_pkg::lane_t result,
  output fpls_pkg::lane_t cost
);
  import fpls_pkg::*;

  lane_t both;

  always_comb begin
    both = set_a & set_b & LANE_MASK;
    if (both == '0) begin
      result = (set_a | set_b) & LANE_MASK;
      cost   = weight;
    end else begin
      result = both;
      cost   = '0;
    end
  end

endmodule

// ===== design/fpls_front.sv =====
// First register stage: sums the lane costs and holds one block's lane results.
// Depends on fpls_pkg.
module fpls_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            mode,
  input  logic [fpls_pkg::SET_W-1:0]      merged,
  input  fpls_pkg::lane_t [fpls_pkg::LANES-1:0] lane_cost,
  input  logic [fpls_pkg::LIMIT_W-1:0]    limit,
  input  logic                            last,
  output logic                            s1_valid,
  output fpls_pkg::stage1_t               s1,
  input  logic                            s1_take
);
  import fpls_pkg::*;

  logic             s1_valid_r;
  stage1_t          s1_r;
  logic [SUM_W-1:0] sum;

  always_comb begin
    sum = '0;
    for (int i = 0; i < LANES; i++) begin
      sum = sum + SUM_W'(lane_cost[i]);
    end
  end

  // The stage refills in the same cycle that its contents move on.
  assign in_ready = !s1_valid_r || s1_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_r.mode   <= mode;
      s1_r.merged <= merged;
      s1_r.added  <= sum;
      s1_r.limit  <= limit;
      s1_r.last   <= last;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

endmodule

// ===== design/fpls_score.sv =====
// Merge stage: running score with saturation, sticky early-stop flag and the result register.
// Depends on fpls_pkg.
module fpls_score (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              s1_valid,
  input  fpls_pkg::stage1_t                 s1,
  output logic                              s1_take,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fpls_pkg::SET_W-1:0]        merged_set,
  output logic [fpls_pkg::OUT_SCORE_W-1:0]  running_score,
  output logic                              limit_exceeded,
  output logic                              last_result
);
  import fpls_pkg::*;

  logic [SCORE_BITS-1:0]  acc_r;
  logic [SCORE_BITS-1:0]  acc_nxt;
  logic                   stop_r;
  logic                   stop_nxt;
  logic [SCORE_BITS:0]    acc_sum;
  logic [SCORE_BITS-1:0]  acc_sat;
  logic [SCORE_BITS-1:0]  acc_new;
  logic                   stop_new;

  logic                   out_valid_r;
  logic [SET_W-1:0]       merged_r;
  logic [OUT_SCORE_W-1:0] score_r;
  logic                   flag_r;
  logic                   last_r;

  assign s1_take = s1_valid && (!out_valid_r || out_ready);

  always_comb begin
    acc_sum = {1'b0, acc_r} + (SCORE_BITS + 1)'(s1.added);
    acc_sat = acc_sum[SCORE_BITS] ? '1 : acc_sum[SCORE_BITS-1:0];
    if (stop_r) begin
      acc_new  = acc_r;
      stop_new = 1'b1;
    end else begin
      acc_new  = acc_sat;
      stop_new = (s1.mode == MODE_SCORE_ONLY) &&
                 (CMP_W'(acc_sat) > CMP_W'(s1.limit));
    end
    // The end of a comparison clears the state only after its beat is built.
    if (s1.last) begin
      acc_nxt  = '0;
      stop_nxt = 1'b0;
    end else begin
      acc_nxt  = acc_new;
      stop_nxt = stop_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_take) begin
        acc_r  <= acc_nxt;
        stop_r <= stop_nxt;
      end
      if (s1_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      merged_r <= (s1.mode == MODE_SCORE_ONLY) ? '0 : s1.merged;
      score_r  <= OUT_SCORE_W'(CMP_W'(acc_new));
      flag_r   <= stop_new;
      last_r   <= s1.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign merged_set     = merged_r;
  assign running_score  = score_r;
  assign limit_exceeded = flag_r;
  assign last_result    = last_r;

endmodule

// ===== design/fitch_parsimony_lane_step.sv =====
// Weighted Fitch parsimony step: one block of sites per beat, one result beat per block.
// An input beat passes the stage 1 register, then the result register, to the output.
// One block per cycle unless the output stalls; the score register updates once per block.
// The lanes and the weight sum fill the first register stage, the score sits in the second.
// Synchronous active-low reset clears the score, the stop flag and both valid stages.
// Depends on fpls_pkg, fpls_if, fpls_lane, fpls_front and fpls_score.
module fitch_parsimony_lane_step (
  input  logic         clk,
  input  logic         rst_n,
  fpls_in_if.sink      in_bus,
  fpls_out_if.source   out_bus
);
  import fpls_pkg::*;

  lane_t [LANES-1:0] lane_res;
  lane_t [LANES-1:0] lane_cost;
  logic [SET_W-1:0]  merged;
  logic              s1_valid;
  stage1_t           s1;
  logic              s1_take;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    fpls_lane u_lane (
      .set_a  (in_bus.set_a[g*LANE_W +: LANE_W]),
      .set_b  (in_bus.set_b[g*LANE_W +: LANE_W]),
      .weight (in_bus.site_weights[g*LANE_W +: LANE_W]),
      .result (lane_res[g]),
      .cost   (lane_cost[g])
    );
  end

  // Bytes above the last lane stay zero.
  always_comb begin
    merged = '0;
    for (int i = 0; i < LANES; i++) begin
      merged[i*LANE_W +: LANE_W] = lane_res[i];
    end
  end

  fpls_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .mode      (in_bus.mode),
    .merged    (merged),
    .lane_cost (lane_cost),
    .limit     (in_bus.score_limit),
    .last      (in_bus.last_block),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .s1_take   (s1_take)
  );

  fpls_score u_score (
    .clk            (clk),
    .rst_n          (rst_n),
    .s1_valid       (s1_valid),
    .s1             (s1),
    .s1_take        (s1_take),
    .out_valid      (out_bus.valid),
    .out_ready      (out_bus.ready),
    .merged_set     (out_bus.merged_set),
    .running_score  (out_bus.running_score),
    .limit_exceeded (out_bus.limit_exceeded),
    .last_result    (out_bus.last_result)
  );

endmodule

// ===== design/fpls_checker.sv =====
// Port-level checks for the parsimony block and the bind that attaches them.
// Depends on fpls_pkg and the top level fitch_parsimony_lane_step.
module fpls_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [fpls_pkg::OUT_SCORE_W-1:0] running_score,
  input logic                             limit_exceeded
);
  import fpls_pkg::*;

  // A result beat is not withdrawn before it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // Input is held off only when a result beat waits at the output.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with a free output");

  // The stop flag trips only on a score above a limit, so the score is nonzero.
  a_stop_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && limit_exceeded |-> running_score != '0)
    else $error("stop flag set with zero score");

  // Reset empties the output stage.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind fitch_parsimony_lane_step fpls_checker u_fpls_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_bus.valid),
  .in_ready       (in_bus.ready),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .running_score  (out_bus.running_score),
  .limit_exceeded (out_bus.limit_exceeded)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for fitch_parsimony_lane_step: Fitch merge, weighted score, early stop.
// Depends on fpls_pkg and the fpls_in_if / fpls_out_if channel interfaces of the design.
module tb;
  import fpls_pkg::*;

  localparam logic MODE_MERGE = ~MODE_SCORE_ONLY;
  localparam int MAX_IDLE = 18;
  localparam int RANDOM_ITEMS = 450;
  localparam int HOLD_CYCLES = 120;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam longint unsigned SCORE_SAT = (64'd1 << SCORE_BITS) - 1;

  typedef struct packed {
    logic               mode;
    logic [SET_W-1:0]   set_a;
    logic [SET_W-1:0]   set_b;
    logic [SET_W-1:0]   site_weights;
    logic [LIMIT_W-1:0] score_limit;
    logic               last_block;
  } block_t;

  typedef struct packed {
    logic [SET_W-1:0]       merged_set;
    logic [OUT_SCORE_W-1:0] running_score;
    logic                   limit_exceeded;
    logic                   last_result;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  fpls_in_if  in_if ();
  fpls_out_if out_if ();

  fitch_parsimony_lane_step uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted state of the comparison in progress.
  longint unsigned run_score = 0;
  bit              run_stopped = 1'b0;

  result_t pending_results[$];
  int      mismatch_count = 0;
  int      idle_cycles = 0;
  int      hold_cycles = 0;
  bit      send_idle_on = 1'b1;
  bit      recv_idle_on = 1'b1;

  function automatic result_t fitch_predict(block_t blk);
    result_t         r;
    lane_t           sa, sb, both;
    int unsigned     added;
    longint unsigned total;
    int              l;
    r = '0;
    added = 0;
    for (l = 0; l < LANES; l++) begin
      sa = blk.set_a[LANE_W*l +: LANE_W];
      sb = blk.set_b[LANE_W*l +: LANE_W];
      both = sa & sb;
      if (both == '0) begin
        r.merged_set[LANE_W*l +: LANE_W] = sa | sb;
        added = added + 32'(blk.site_weights[LANE_W*l +: LANE_W]);
      end else begin
        r.merged_set[LANE_W*l +: LANE_W] = both;
      end
    end
    if (!run_stopped) begin
      total = run_score + 64'(added);
      run_score = (total > SCORE_SAT) ? SCORE_SAT : total;
      if (blk.mode == MODE_SCORE_ONLY && run_score > 64'(blk.score_limit))
        run_stopped = 1'b1;
    end
    if (blk.mode == MODE_SCORE_ONLY)
      r.merged_set = '0;
    r.running_score = run_score[OUT_SCORE_W-1:0];
    r.limit_exceeded = run_stopped;
    r.last_result = blk.last_block;
    if (blk.last_block) begin
      run_score = 0;
      run_stopped = 1'b0;
    end
    return r;
  endfunction

  function automatic int draw_idle(bit enabled);
    if (!enabled)
      return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, MAX_IDLE));
  endfunction

  function automatic block_t blk_of(logic mode, logic [SET_W-1:0] a, logic [SET_W-1:0] b,
                                    logic [SET_W-1:0] w, logic [LIMIT_W-1:0] lim,
                                    logic last);
    block_t blk;
    blk.mode = mode;
    blk.set_a = a;
    blk.set_b = b;
    blk.site_weights = w;
    blk.score_limit = lim;
    blk.last_block = last;
    return blk;
  endfunction

  // Sites shaped like real state sets: disjoint, overlapping, equal, singletons or raw.
  function automatic block_t random_sites();
    block_t blk;
    lane_t  sa, sb;
    int     l, k;
    blk = '0;
    for (l = 0; l < LANES; l++) begin
      k = $urandom_range(0, 7);
      case ($urandom_range(0, 4))
        0: begin
          sa = lane_t'($urandom);
          sb = lane_t'($urandom) & ~sa;
        end
        1: begin
          sa = lane_t'($urandom) | lane_t'(1 << k);
          sb = lane_t'($urandom) | lane_t'(1 << k);
        end
        2: begin
          sa = lane_t'($urandom);
          sb = sa;
        end
        3: begin
          sa = lane_t'(1 << k);
          sb = lane_t'(1 << $urandom_range(0, 7));
        end
        default: begin
          sa = lane_t'($urandom);
          sb = lane_t'($urandom);
        end
      endcase
      blk.set_a[LANE_W*l +: LANE_W] = sa;
      blk.set_b[LANE_W*l +: LANE_W] = sb;
      case ($urandom_range(0, 3))
        0: blk.site_weights[LANE_W*l +: LANE_W] = '0;
        1: blk.site_weights[LANE_W*l +: LANE_W] = LANE_MASK;
        default: blk.site_weights[LANE_W*l +: LANE_W] = lane_t'($urandom);
      endcase
    end
    return blk;
  endfunction

  // Offers one block after a random gap and records its prediction on acceptance.
  task automatic send_block(block_t blk);
    int gap;
    gap = draw_idle(send_idle_on);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.mode         <= blk.mode;
    in_if.set_a        <= blk.set_a;
    in_if.set_b        <= blk.set_b;
    in_if.site_weights <= blk.site_weights;
    in_if.score_limit  <= blk.score_limit;
    in_if.last_block   <= blk.last_block;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(fitch_predict(blk));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_block(blk_of(MODE_MERGE, '0, '0, {8{8'hFF}}, '0, 1'b0));
    send_block(blk_of(MODE_MERGE, {8{8'hFF}}, {8{8'hFF}}, {8{8'hFF}}, '0, 1'b0));
    send_block(blk_of(MODE_MERGE, {8{8'h0F}}, {8{8'hF0}}, 64'h0807060504030201,
                      24'hFFFFFF, 1'b1));
    // Score equal to the limit does not stop; one more block over it does.
    send_block(blk_of(MODE_SCORE_ONLY, {8{8'h01}}, {8{8'h02}}, {8{8'h01}}, 24'd8, 1'b0));
    send_block(blk_of(MODE_SCORE_ONLY, {8{8'h01}}, {8{8'h02}}, {8{8'h01}}, 24'd15, 1'b0));
    send_block(blk_of(MODE_SCORE_ONLY, {8{8'h01}}, {8{8'h02}}, {8{8'hFF}}, 24'hFFFFFF,
                      1'b0));
    // A stopped run still merges in mode 0 but adds nothing.
    send_block(blk_of(MODE_MERGE, {8{8'hAA}}, {8{8'h55}}, {8{8'hFF}}, '0, 1'b0));
    send_block(blk_of(MODE_MERGE, 64'h8040201008040201, 64'h80C0E0F0F8FCFEFF, {8{8'h10}},
                      '0, 1'b1));
    send_block(blk_of(MODE_SCORE_ONLY, {8{8'h0C}}, {8{8'h30}}, '0, '0, 1'b0));
    send_block(blk_of(MODE_SCORE_ONLY, 64'h0100000000000000, 64'h0200000000000000,
                      64'h0100000000000000, '0, 1'b1));
    send_block(blk_of(MODE_SCORE_ONLY, {8{8'h01}}, {8{8'h80}}, {8{8'hFF}}, 24'hFFFFFF,
                      1'b1));
    send_block(blk_of(MODE_MERGE, 64'hFF00FF00AA55F00F, 64'h00FF0F00AA0A0FF0,
                      64'hA55AFF0000FF5AA5, 24'h000001, 1'b1));
    drain_results();
  endtask

  task automatic test_backpressure();
    send_idle_on = 1'b0;
    hold_cycles = HOLD_CYCLES;
    repeat (30) send_block(random_sites());
    send_idle_on = 1'b1;
    // Sender waits for every outstanding result before going on.
    drain_results();
    repeat (10) send_block(random_sites());
  endtask

  task automatic test_random_comparisons();
    int                 sent, len, mode_pick, i;
    block_t             blk;
    logic [LIMIT_W-1:0] lim;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      send_idle_on = ($urandom_range(0, 4) != 0);
      recv_idle_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) == 0) begin
        blk = blk_of($urandom_range(0, 1) ? MODE_SCORE_ONLY : MODE_MERGE,
                     {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     LIMIT_W'($urandom), 1'($urandom_range(0, 1)));
        send_block(blk);
        sent++;
      end else begin
        len = $urandom_range(1, 12);
        mode_pick = $urandom_range(0, 2);
        case ($urandom_range(0, 4))
          0: lim = '0;
          1: lim = '1;
          2: lim = LIMIT_W'($urandom);
          default: lim = LIMIT_W'($urandom_range(0, len * 1000));
        endcase
        for (i = 0; i < len; i++) begin
          blk = random_sites();
          case (mode_pick)
            0: blk.mode = MODE_MERGE;
            1: blk.mode = MODE_SCORE_ONLY;
            default: blk.mode = $urandom_range(0, 1) ? MODE_SCORE_ONLY : MODE_MERGE;
          endcase
          blk.score_limit = lim;
          blk.last_block = (i == len - 1);
          send_block(blk);
          sent++;
        end
      end
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    drain_results();
  endtask

  // Result side: random stalls per beat, plus a long hold-off when one is requested.
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = draw_idle(recv_idle_on);
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation waiting");
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_if.merged_set !== exp_r.merged_set) begin
          $error("merged_set: expected %h, got %h", exp_r.merged_set, out_if.merged_set);
          mismatch_count++;
        end
        if (out_if.running_score !== exp_r.running_score) begin
          $error("running_score: expected %0d, got %0d", exp_r.running_score,
                 out_if.running_score);
          mismatch_count++;
        end
        if (out_if.limit_exceeded !== exp_r.limit_exceeded) begin
          $error("limit_exceeded: expected %b, got %b", exp_r.limit_exceeded,
                 out_if.limit_exceeded);
          mismatch_count++;
        end
        if (out_if.last_result !== exp_r.last_result) begin
          $error("last_result: expected %b, got %b", exp_r.last_result, out_if.last_result);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL fitch_parsimony_lane_step");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.mode = MODE_MERGE;
    in_if.set_a = '0;
    in_if.set_b = '0;
    in_if.site_weights = '0;
    in_if.score_limit = '0;
    in_if.last_block = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_backpressure();
    test_random_comparisons();

    drain_results();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      mismatch_count++;
    if (mismatch_count == 0) begin
      $display("PASS fitch_parsimony_lane_step");
    end else begin
      $display("FAIL fitch_parsimony_lane_step");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/fpls_pkg.sv
design/fpls_if.sv
design/fpls_lane.sv
design/fpls_front.sv
design/fpls_score.sv
design/fitch_parsimony_lane_step.sv
design/fpls_checker.sv
tb/tb.sv
